// ===== rtl/nand_page_command_sequencer_top_macros.svh =====
// Assertion macros for the sequencer checker.
`ifndef NAND_PAGE_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define NAND_PAGE_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define NPCS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npcs same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define NPCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("npcs next-cycle check failed");

`endif

// ===== rtl/npcs_pkg.sv =====
// Types and constants shared by the NAND page command sequencer.
`timescale 1ns / 1ps
package npcs_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        FN_READ_ID    = 3'd0,
        FN_START_READ = 3'd1,
        FN_NEXT_READ  = 3'd2,
        FN_START_PROG = 3'd3,
        FN_PROG_BYTE  = 3'd4,
        FN_ERASE      = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        K_SEL   = 3'd0,
        K_CMD   = 3'd1,
        K_ADDR  = 3'd2,
        K_DOUT  = 3'd3,
        K_DIN   = 3'd4,
        K_WAIT  = 3'd5,
        K_DESEL = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        MD_IDLE = 2'd0,
        MD_READ = 2'd1,
        MD_PROG = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        OP_READ_ID,
        OP_START_RD,
        OP_START_PG,
        OP_ZERO_LEN,
        OP_RD,
        OP_RD_END,
        OP_RD_PAGE,
        OP_PG,
        OP_PG_END,
        OP_PG_PAGE,
        OP_ERASE,
        OP_REJECT
    } t_op;

    localparam logic [7:0] CMD_READ_ID = 8'h90;
    localparam logic [7:0] ID_ADDR     = 8'h00;
    localparam logic [7:0] CMD_READ_1  = 8'h00;
    localparam logic [7:0] CMD_READ_2  = 8'h30;
    localparam logic [7:0] CMD_PROG_1  = 8'h80;
    localparam logic [7:0] CMD_PROG_2  = 8'h10;
    localparam logic [7:0] CMD_ERASE_1 = 8'h60;
    localparam logic [7:0] CMD_ERASE_2 = 8'hD0;

    // One classified request, as handed from front to back.
    typedef struct packed {
        t_op         op;
        logic [15:0] col;
        logic [23:0] row;
        logic [7:0]  data;
    } t_job;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cbyte;
    } t_cycle;

endpackage

// ===== rtl/nand_page_command_sequencer_top.sv =====
// Top level of the NAND page command sequencer.
//
// Requests enter through a push/full queue port: a word is taken on a rising
// edge with push high and full low. Bus cycle words leave through an
// empty/pop port: the oldest word is shown while empty is low and is taken on
// an edge with pop high. Every request yields one to nine words, the final
// one flagged by o_last_of_run; a request that does not fit the mode yields a
// single select word with o_rejected set.
// The front end classifies each request in the cycle it is taken and updates
// mode and page position at once, so requests are taken back to back while
// the four-entry job queue has room. The back end emits one word per clock
// while its output is drained, expanding each request word by word (one
// word for a streamed data byte, up to nine with a page header); the first
// word of a request goes through the job queue and the output register.
// When pop stays low the output word holds, the back end stops, and full
// rises once the job queue fills. Reset clears mode, page position, queue
// and output valid flag; the block takes requests on the next cycle.
`timescale 1ns / 1ps
module nand_page_command_sequencer_top #(
    parameter int PAGE_BYTES      = 2048,
    parameter int PAGES_PER_BLOCK = 64,
    parameter int ADDRESS_BITS    = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [27:0] i_byte_address,
    input  logic [27:0] i_transfer_length,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_cycle_kind,
    output logic [7:0]  o_cycle_byte,
    output logic        o_last_of_run,
    output logic        o_rejected
);

    npcs_pkg::t_job job;
    npcs_pkg::t_job head;
    logic           accept;
    logic           head_valid;
    logic           head_pop;

    assign accept = push && !full;

    npcs_front #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_func            (i_func),
        .i_byte_address    (i_byte_address),
        .i_transfer_length (i_transfer_length),
        .i_write_data      (i_write_data),
        .o_job             (job)
    );

    npcs_jobq u_jobq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (accept),
        .i_job        (job),
        .o_full       (full),
        .i_rd         (head_pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    npcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_head_pop    (head_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_cycle_kind  (o_cycle_kind),
        .o_cycle_byte  (o_cycle_byte),
        .o_last_of_run (o_last_of_run),
        .o_rejected    (o_rejected)
    );

endmodule

// ===== rtl/npcs_front.sv =====
// Front end: classifies requests against the current mode and tracks page position.
`timescale 1ns / 1ps
module npcs_front #(
    parameter int PAGE_BYTES      = 2048,
    parameter int PAGES_PER_BLOCK = 64,
    parameter int ADDRESS_BITS    = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_func,
    input  logic [27:0]      i_byte_address,
    input  logic [27:0]      i_transfer_length,
    input  logic [7:0]       i_write_data,
    output npcs_pkg::t_job   o_job
);

    localparam int COL_W     = $clog2(PAGE_BYTES);
    localparam int BLK_W     = $clog2(PAGES_PER_BLOCK);
    localparam int MASK_BITS = (ADDRESS_BITS < 28) ? ADDRESS_BITS : 28;
    localparam logic [27:0] ADDR_MASK = 28'((64'(1) << MASK_BITS) - 64'(1));
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(PAGE_BYTES - 1);

    npcs_pkg::t_mode  r_mode, n_mode;
    logic [23:0]      r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [27:0]      r_left, n_left;

    logic [27:0]      addr_m;
    logic [23:0]      ld_row;
    logic [COL_W-1:0] ld_col;
    logic [23:0]      er_row;
    logic [27:0]      left_dec;
    logic [23:0]      row_inc;
    logic             left_zero;
    logic             page_end;
    logic             is_idle;

    assign addr_m    = i_byte_address & ADDR_MASK;
    assign ld_row    = 24'(addr_m >> COL_W);
    assign ld_col    = addr_m[COL_W-1:0];
    assign er_row    = 24'((addr_m >> (COL_W + BLK_W)) << BLK_W);
    assign left_dec  = r_left - 28'd1;
    assign left_zero = (left_dec == 28'd0);
    assign row_inc   = r_row + 24'd1;
    assign page_end  = (r_col == COL_LAST);
    assign is_idle   = (r_mode == npcs_pkg::MD_IDLE);

    // Classify the request
    always_comb begin
        o_job.op   = npcs_pkg::OP_REJECT;
        o_job.col  = 16'(r_col);
        o_job.row  = r_row;
        o_job.data = i_write_data;
        priority if (i_func == npcs_pkg::FN_READ_ID && is_idle) begin
            o_job.op = npcs_pkg::OP_READ_ID;
        end else if ((i_func == npcs_pkg::FN_START_READ || i_func == npcs_pkg::FN_START_PROG)
                     && is_idle) begin
            o_job.col = 16'(ld_col);
            o_job.row = ld_row;
            if (i_transfer_length == 28'd0) begin
                o_job.op = npcs_pkg::OP_ZERO_LEN;
            end else if (i_func == npcs_pkg::FN_START_READ) begin
                o_job.op = npcs_pkg::OP_START_RD;
            end else begin
                o_job.op = npcs_pkg::OP_START_PG;
            end
        end else if (i_func == npcs_pkg::FN_NEXT_READ && r_mode == npcs_pkg::MD_READ) begin
            o_job.col = 16'd0;
            o_job.row = row_inc;
            if (left_zero) begin
                o_job.op = npcs_pkg::OP_RD_END;
            end else if (page_end) begin
                o_job.op = npcs_pkg::OP_RD_PAGE;
            end else begin
                o_job.op = npcs_pkg::OP_RD;
            end
        end else if (i_func == npcs_pkg::FN_PROG_BYTE && r_mode == npcs_pkg::MD_PROG) begin
            o_job.col = 16'd0;
            o_job.row = row_inc;
            if (left_zero) begin
                o_job.op = npcs_pkg::OP_PG_END;
            end else if (page_end) begin
                o_job.op = npcs_pkg::OP_PG_PAGE;
            end else begin
                o_job.op = npcs_pkg::OP_PG;
            end
        end else if (i_func == npcs_pkg::FN_ERASE && is_idle) begin
            o_job.op  = npcs_pkg::OP_ERASE;
            o_job.row = er_row;
        end else begin
            o_job.op = npcs_pkg::OP_REJECT;
        end
    end

    // Next mode and page position from the classification
    always_comb begin
        n_mode = r_mode;
        n_row  = r_row;
        n_col  = r_col;
        n_left = r_left;
        unique case (o_job.op)
            npcs_pkg::OP_START_RD, npcs_pkg::OP_START_PG: begin
                n_mode = (o_job.op == npcs_pkg::OP_START_RD) ? npcs_pkg::MD_READ
                                                             : npcs_pkg::MD_PROG;
                n_row  = ld_row;
                n_col  = ld_col;
                n_left = i_transfer_length;
            end
            npcs_pkg::OP_RD_END, npcs_pkg::OP_PG_END: begin
                n_mode = npcs_pkg::MD_IDLE;
                n_left = left_dec;
            end
            npcs_pkg::OP_RD_PAGE, npcs_pkg::OP_PG_PAGE: begin
                n_row  = row_inc;
                n_col  = '0;
                n_left = left_dec;
            end
            npcs_pkg::OP_RD, npcs_pkg::OP_PG: begin
                n_col  = r_col + COL_W'(1);
                n_left = left_dec;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= npcs_pkg::MD_IDLE;
            r_row  <= '0;
            r_col  <= '0;
            r_left <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_row  <= n_row;
            r_col  <= n_col;
            r_left <= n_left;
        end
    end

endmodule

// ===== rtl/npcs_jobq.sv =====
// Short job queue between the front end and the cycle generator.
`timescale 1ns / 1ps
module npcs_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  npcs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_head_valid,
    output npcs_pkg::t_job o_head
);

    localparam logic [npcs_pkg::QPTR_W:0] CNT_FULL = (npcs_pkg::QPTR_W + 1)'(npcs_pkg::QDEPTH);

    npcs_pkg::t_job                r_mem [npcs_pkg::QDEPTH];
    logic [npcs_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [npcs_pkg::QPTR_W:0]     r_cnt, n_cnt;
    logic                          do_wr, do_rd;

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign do_wr        = i_wr && !o_full;
    assign do_rd        = i_rd && o_head_valid;

    always_comb begin
        unique case ({do_wr, do_rd})
            2'b10:   n_cnt = r_cnt + (npcs_pkg::QPTR_W + 1)'(1);
            2'b01:   n_cnt = r_cnt - (npcs_pkg::QPTR_W + 1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_wr) begin
                r_wp <= r_wp + npcs_pkg::QPTR_W'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + npcs_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/npcs_back.sv =====
// Back end: expands each job into bus cycle words, one per clock while the output register is free or drained.
`timescale 1ns / 1ps
module npcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  npcs_pkg::t_job i_head,
    output logic           o_head_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [2:0]     o_cycle_kind,
    output logic [7:0]     o_cycle_byte,
    output logic           o_last_of_run,
    output logic           o_rejected
);

    npcs_pkg::t_step  r_step, n_step;
    logic             r_valid, n_valid;
    npcs_pkg::t_cycle r_cyc;
    logic             r_last, r_rej;

    npcs_pkg::t_cycle c_cyc;
    logic             c_last, c_rej;
    logic             adv;
    logic [2:0]       hdr_idx;
    logic [2:0]       pg_idx;

    // Page header: command, two column bytes, three row bytes
    function automatic npcs_pkg::t_cycle hdr_cycle(
        input logic [2:0]  idx,
        input logic [7:0]  cmd,
        input logic [15:0] col,
        input logic [23:0] row
    );
        npcs_pkg::t_cycle c;
        c.kind = (idx == 3'd0) ? npcs_pkg::K_CMD : npcs_pkg::K_ADDR;
        unique case (idx)
            3'd0:    c.cbyte = cmd;
            3'd1:    c.cbyte = col[7:0];
            3'd2:    c.cbyte = col[15:8];
            3'd3:    c.cbyte = row[7:0];
            3'd4:    c.cbyte = row[15:8];
            default: c.cbyte = row[23:16];
        endcase
        return c;
    endfunction

    assign hdr_idx = 3'(r_step - npcs_pkg::t_step'(1));
    assign pg_idx  = 3'(r_step - npcs_pkg::t_step'(3));

    always_comb begin
        c_cyc.kind  = npcs_pkg::K_SEL;
        c_cyc.cbyte = 8'h00;
        c_last      = 1'b0;
        c_rej       = 1'b0;
        unique case (i_head.op)
            npcs_pkg::OP_READ_ID: begin
                priority if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_SEL;
                end else if (r_step == npcs_pkg::t_step'(1)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_READ_ID;
                end else if (r_step == npcs_pkg::t_step'(2)) begin
                    c_cyc.kind  = npcs_pkg::K_ADDR;
                    c_cyc.cbyte = npcs_pkg::ID_ADDR;
                end else if (r_step <= npcs_pkg::t_step'(7)) begin
                    c_cyc.kind = npcs_pkg::K_DIN;
                end else begin
                    c_cyc.kind = npcs_pkg::K_DESEL;
                    c_last     = 1'b1;
                end
            end
            npcs_pkg::OP_START_RD: begin
                priority if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_SEL;
                end else if (r_step <= npcs_pkg::t_step'(6)) begin
                    c_cyc = hdr_cycle(hdr_idx, npcs_pkg::CMD_READ_1, i_head.col, i_head.row);
                end else if (r_step == npcs_pkg::t_step'(7)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_READ_2;
                end else begin
                    c_cyc.kind = npcs_pkg::K_WAIT;
                    c_last     = 1'b1;
                end
            end
            npcs_pkg::OP_START_PG: begin
                if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_SEL;
                end else begin
                    c_cyc = hdr_cycle(hdr_idx, npcs_pkg::CMD_PROG_1, i_head.col, i_head.row);
                end
                c_last = (r_step == npcs_pkg::t_step'(6));
            end
            npcs_pkg::OP_ZERO_LEN: begin
                if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_SEL;
                end else begin
                    c_cyc.kind = npcs_pkg::K_DESEL;
                    c_last     = 1'b1;
                end
            end
            npcs_pkg::OP_RD: begin
                c_cyc.kind = npcs_pkg::K_DIN;
                c_last     = 1'b1;
            end
            npcs_pkg::OP_RD_END: begin
                if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_DIN;
                end else begin
                    c_cyc.kind = npcs_pkg::K_DESEL;
                    c_last     = 1'b1;
                end
            end
            npcs_pkg::OP_RD_PAGE: begin
                priority if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_DIN;
                end else if (r_step <= npcs_pkg::t_step'(6)) begin
                    c_cyc = hdr_cycle(hdr_idx, npcs_pkg::CMD_READ_1, i_head.col, i_head.row);
                end else if (r_step == npcs_pkg::t_step'(7)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_READ_2;
                end else begin
                    c_cyc.kind = npcs_pkg::K_WAIT;
                    c_last     = 1'b1;
                end
            end
            npcs_pkg::OP_PG: begin
                c_cyc.kind  = npcs_pkg::K_DOUT;
                c_cyc.cbyte = i_head.data;
                c_last      = 1'b1;
            end
            npcs_pkg::OP_PG_END, npcs_pkg::OP_PG_PAGE: begin
                priority if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind  = npcs_pkg::K_DOUT;
                    c_cyc.cbyte = i_head.data;
                end else if (r_step == npcs_pkg::t_step'(1)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_PROG_2;
                end else if (r_step == npcs_pkg::t_step'(2)) begin
                    c_cyc.kind = npcs_pkg::K_WAIT;
                end else if (i_head.op == npcs_pkg::OP_PG_END) begin
                    c_cyc.kind = npcs_pkg::K_DESEL;
                    c_last     = 1'b1;
                end else begin
                    // page turned: open the next page with a fresh header
                    c_cyc  = hdr_cycle(pg_idx, npcs_pkg::CMD_PROG_1, i_head.col, i_head.row);
                    c_last = (r_step == npcs_pkg::t_step'(8));
                end
            end
            npcs_pkg::OP_ERASE: begin
                priority if (r_step == npcs_pkg::t_step'(0)) begin
                    c_cyc.kind = npcs_pkg::K_SEL;
                end else if (r_step == npcs_pkg::t_step'(1)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_ERASE_1;
                end else if (r_step <= npcs_pkg::t_step'(4)) begin
                    // row bytes only, no column
                    c_cyc = hdr_cycle(3'(r_step + npcs_pkg::t_step'(1)), npcs_pkg::CMD_ERASE_1,
                                      i_head.col, i_head.row);
                end else if (r_step == npcs_pkg::t_step'(5)) begin
                    c_cyc.kind  = npcs_pkg::K_CMD;
                    c_cyc.cbyte = npcs_pkg::CMD_ERASE_2;
                end else if (r_step == npcs_pkg::t_step'(6)) begin
                    c_cyc.kind = npcs_pkg::K_WAIT;
                end else begin
                    c_cyc.kind = npcs_pkg::K_DESEL;
                    c_last     = 1'b1;
                end
            end
            default: begin
                c_cyc.kind = npcs_pkg::K_SEL;
                c_last     = 1'b1;
                c_rej      = 1'b1;
            end
        endcase
    end

    // Advance when a job waits and the output slot is free or being drained
    assign adv        = i_head_valid && (!r_valid || i_pop);
    assign o_head_pop = adv && c_last;

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (adv) begin
            n_valid = 1'b1;
            n_step  = c_last ? '0 : r_step + npcs_pkg::t_step'(1);
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cyc  <= c_cyc;
            r_last <= c_last;
            r_rej  <= c_rej;
        end
    end

    assign o_empty       = !r_valid;
    assign o_cycle_kind  = r_cyc.kind;
    assign o_cycle_byte  = r_cyc.cbyte;
    assign o_last_of_run = r_last;
    assign o_rejected    = r_rej;

endmodule

// ===== rtl/npcs_checker.sv =====
// Port-level checker for the NAND page command sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "nand_page_command_sequencer_top_macros.svh"
module npcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_cycle_kind,
    input logic [7:0] o_cycle_byte,
    input logic       o_last_of_run,
    input logic       o_rejected
);

    logic        shown;
    logic        is_sel;
    logic [12:0] word_bits;

    assign shown     = !empty;
    assign is_sel    = (o_cycle_kind == npcs_pkg::K_SEL);
    assign word_bits = {o_cycle_kind, o_cycle_byte, o_last_of_run, o_rejected};

    // A word left waiting stays put
    `NPCS_ASSERT_NEXT(a_hold, shown && !pop, shown && $stable(word_bits))

    // Deselect always closes the run
    `NPCS_ASSERT_NOW(a_desel_last, shown && o_cycle_kind == npcs_pkg::K_DESEL, o_last_of_run)

    // Select ends a run only when it is a rejection
    `NPCS_ASSERT_NOW(a_sel_last, shown && is_sel, o_last_of_run == o_rejected)

    // A rejection is a lone select word with a zero byte
    `NPCS_ASSERT_NOW(a_reject_form, shown && o_rejected, is_sel && o_cycle_byte == 8'h00)

endmodule

bind nand_page_command_sequencer_top npcs_checker u_npcs_checker (.*);

// ===== dv/tb_nand_page_command_sequencer_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the NAND page command sequencer top level.
module tb_nand_page_command_sequencer_top;

    localparam int PAGE_BYTES      = 2048;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int RANDOM_TARGET   = 455;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES    = 24;

    // func codes outside the defined set
    localparam logic [2:0] FN_UNUSED_A = 3'd6;
    localparam logic [2:0] FN_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [27:0] addr;
        logic [27:0] len;
        logic [7:0]  data;
    } t_request;

    typedef struct packed {
        npcs_pkg::t_kind kind;
        logic [7:0]      cbyte;
        logic            last;
        logic            rej;
    } t_bus_word;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic        full;
    logic [2:0]  i_func            = '0;
    logic [27:0] i_byte_address    = '0;
    logic [27:0] i_transfer_length = '0;
    logic [7:0]  i_write_data      = '0;
    logic        empty;
    logic        pop               = 1'b0;
    logic [2:0]  o_cycle_kind;
    logic [7:0]  o_cycle_byte;
    logic        o_last_of_run;
    logic        o_rejected;

    nand_page_command_sequencer_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request  requests_pending[$];
    t_bus_word bus_words_due[$];
    t_bus_word cycle_run[$];

    // shadow of the sequencer state
    npcs_pkg::t_mode shadow_mode = npcs_pkg::MD_IDLE;
    logic [23:0]     page_row    = '0;
    logic [11:0]     col_pos     = '0;
    logic [27:0]     bytes_left  = '0;

    int unsigned mismatch_count = 0;
    int unsigned words_checked  = 0;
    int unsigned items_taken    = 0;
    int unsigned reject_count   = 0;
    int unsigned erase_count    = 0;
    int unsigned page_turns     = 0;
    int unsigned cycle_count    = 0;

    task automatic add_cycle(input npcs_pkg::t_kind k, input logic [7:0] b);
        cycle_run.push_back('{kind: k, cbyte: b, last: 1'b0, rej: 1'b0});
    endtask

    task automatic add_header(input logic [7:0] cmd);
        add_cycle(npcs_pkg::K_CMD, cmd);
        add_cycle(npcs_pkg::K_ADDR, col_pos[7:0]);
        add_cycle(npcs_pkg::K_ADDR, 8'(col_pos >> 8));
        add_cycle(npcs_pkg::K_ADDR, page_row[7:0]);
        add_cycle(npcs_pkg::K_ADDR, page_row[15:8]);
        add_cycle(npcs_pkg::K_ADDR, page_row[23:16]);
    endtask

    task automatic add_read_header();
        add_header(npcs_pkg::CMD_READ_1);
        add_cycle(npcs_pkg::K_CMD, npcs_pkg::CMD_READ_2);
        add_cycle(npcs_pkg::K_WAIT, 8'h00);
    endtask

    task automatic next_page();
        col_pos  = '0;
        page_row = page_row + 24'd1;
        page_turns++;
    endtask

    // Work out the bus words one accepted request produces and queue them.
    task automatic predict_bus_cycles(input t_request req);
        t_bus_word   w;
        logic        page_end;
        logic        rejected;
        logic [23:0] blk_row;
        cycle_run.delete();
        rejected = 1'b0;
        if (req.func == npcs_pkg::FN_READ_ID && shadow_mode == npcs_pkg::MD_IDLE) begin
            add_cycle(npcs_pkg::K_SEL, 8'h00);
            add_cycle(npcs_pkg::K_CMD, npcs_pkg::CMD_READ_ID);
            add_cycle(npcs_pkg::K_ADDR, npcs_pkg::ID_ADDR);
            repeat (5) add_cycle(npcs_pkg::K_DIN, 8'h00);
            add_cycle(npcs_pkg::K_DESEL, 8'h00);
        end else if ((req.func == npcs_pkg::FN_START_READ || req.func == npcs_pkg::FN_START_PROG)
                     && shadow_mode == npcs_pkg::MD_IDLE) begin
            add_cycle(npcs_pkg::K_SEL, 8'h00);
            if (req.len == '0) begin
                add_cycle(npcs_pkg::K_DESEL, 8'h00);
            end else begin
                page_row   = 24'(req.addr / PAGE_BYTES);
                col_pos    = 12'(req.addr % PAGE_BYTES);
                bytes_left = req.len;
                if (req.func == npcs_pkg::FN_START_READ) begin
                    add_read_header();
                    shadow_mode = npcs_pkg::MD_READ;
                end else begin
                    add_header(npcs_pkg::CMD_PROG_1);
                    shadow_mode = npcs_pkg::MD_PROG;
                end
            end
        end else if (req.func == npcs_pkg::FN_NEXT_READ && shadow_mode == npcs_pkg::MD_READ) begin
            add_cycle(npcs_pkg::K_DIN, 8'h00);
            bytes_left = bytes_left - 28'd1;
            col_pos    = col_pos + 12'd1;
            if (bytes_left == '0) begin
                add_cycle(npcs_pkg::K_DESEL, 8'h00);
                shadow_mode = npcs_pkg::MD_IDLE;
            end else if (col_pos >= 12'(PAGE_BYTES)) begin
                next_page();
                add_read_header();
            end
        end else if (req.func == npcs_pkg::FN_PROG_BYTE && shadow_mode == npcs_pkg::MD_PROG) begin
            add_cycle(npcs_pkg::K_DOUT, req.data);
            bytes_left = bytes_left - 28'd1;
            col_pos    = col_pos + 12'd1;
            page_end   = (col_pos >= 12'(PAGE_BYTES));
            // close the page before deselect or before the next header
            if (page_end || bytes_left == '0) begin
                add_cycle(npcs_pkg::K_CMD, npcs_pkg::CMD_PROG_2);
                add_cycle(npcs_pkg::K_WAIT, 8'h00);
            end
            if (bytes_left == '0) begin
                add_cycle(npcs_pkg::K_DESEL, 8'h00);
                shadow_mode = npcs_pkg::MD_IDLE;
            end else if (page_end) begin
                next_page();
                add_header(npcs_pkg::CMD_PROG_1);
            end
        end else if (req.func == npcs_pkg::FN_ERASE && shadow_mode == npcs_pkg::MD_IDLE) begin
            blk_row = 24'((req.addr / (PAGE_BYTES * PAGES_PER_BLOCK)) * PAGES_PER_BLOCK);
            add_cycle(npcs_pkg::K_SEL, 8'h00);
            add_cycle(npcs_pkg::K_CMD, npcs_pkg::CMD_ERASE_1);
            add_cycle(npcs_pkg::K_ADDR, blk_row[7:0]);
            add_cycle(npcs_pkg::K_ADDR, blk_row[15:8]);
            add_cycle(npcs_pkg::K_ADDR, blk_row[23:16]);
            add_cycle(npcs_pkg::K_CMD, npcs_pkg::CMD_ERASE_2);
            add_cycle(npcs_pkg::K_WAIT, 8'h00);
            add_cycle(npcs_pkg::K_DESEL, 8'h00);
            erase_count++;
        end else begin
            add_cycle(npcs_pkg::K_SEL, 8'h00);
            rejected = 1'b1;
            reject_count++;
        end
        foreach (cycle_run[i]) begin
            w      = cycle_run[i];
            w.last = (i == cycle_run.size() - 1);
            w.rej  = rejected;
            bus_words_due.push_back(w);
        end
    endtask

    function automatic t_request rand_request(input logic [2:0] fn);
        t_request r;
        r.func = fn;
        r.addr = 28'($urandom());
        r.len  = 28'($urandom());
        r.data = 8'($urandom());
        return r;
    endfunction

    // Queue a start request, its data words, and now and then an off-mode request.
    task automatic queue_transfer(input logic [2:0] start_fn, input logic [27:0] addr,
                                  input logic [27:0] len, input int unsigned n_data,
                                  input int unsigned noise_pct);
        t_request   r;
        logic [2:0] data_fn;
        logic [2:0] bad_fn;
        data_fn = (start_fn == npcs_pkg::FN_START_READ) ? npcs_pkg::FN_NEXT_READ
                                                        : npcs_pkg::FN_PROG_BYTE;
        r       = rand_request(start_fn);
        r.addr  = addr;
        r.len   = len;
        requests_pending.push_back(r);
        repeat (n_data) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                bad_fn = 3'($urandom_range(0, 6));
                if (bad_fn >= data_fn) bad_fn = bad_fn + 3'd1;
                requests_pending.push_back(rand_request(bad_fn));
            end
            requests_pending.push_back(rand_request(data_fn));
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    t_request    cur_req;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_bus_cycles(cur_req);
                items_taken++;
            end
            if (push && full) begin
                // hold the word until it is taken
            end else if (gap_left != 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (requests_pending.size() != 0) begin
                cur_req           = requests_pending.pop_front();
                i_func            <= cur_req.func;
                i_byte_address    <= cur_req.addr;
                i_transfer_length <= cur_req.len;
                i_write_data      <= cur_req.data;
                push              <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(8, 30);
                        default: gap_left = $urandom_range(1, 5);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: stall rate changes from span to span.
    int unsigned stall_span = 0;
    int unsigned stall_pct  = 0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(20, 150);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            stall_span--;
        end
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_bus_word want;
        if (i_rst_n && pop && !empty) begin
            words_checked++;
            if (bus_words_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected bus word: kind %0d byte %02h last %0b rej %0b",
                             o_cycle_kind, o_cycle_byte, o_last_of_run, o_rejected);
            end else begin
                want = bus_words_due.pop_front();
                if (o_cycle_kind !== want.kind || o_cycle_byte !== want.cbyte ||
                    o_last_of_run !== want.last || o_rejected !== want.rej) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"bus word %0d: expected kind %0d byte %02h last %0b ",
                                  "rej %0b, got kind %0d byte %02h last %0b rej %0b"},
                                 words_checked, want.kind, want.cbyte, want.last, want.rej,
                                 o_cycle_kind, o_cycle_byte, o_last_of_run, o_rejected);
                end
            end
        end
    end

    initial begin
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_request    r;
        int unsigned pick;
        int unsigned len;
        logic [27:0] addr;
        logic [2:0]  fn;

        // directed: extremes, each operation, rejects, zero length, page turns
        requests_pending.push_back(rand_request(npcs_pkg::FN_READ_ID));
        r = rand_request(npcs_pkg::FN_ERASE);
        r.addr = '0;
        r.len  = '0;
        requests_pending.push_back(r);
        r = rand_request(npcs_pkg::FN_ERASE);
        r.addr = '1;
        r.len  = '1;
        requests_pending.push_back(r);
        queue_transfer(npcs_pkg::FN_START_READ, 28'h0ABCDEF, '0, 0, 0);
        queue_transfer(npcs_pkg::FN_START_PROG, '1, '0, 0, 0);
        requests_pending.push_back(rand_request(FN_UNUSED_A));
        requests_pending.push_back(rand_request(FN_UNUSED_B));
        requests_pending.push_back(rand_request(npcs_pkg::FN_NEXT_READ));
        requests_pending.push_back(rand_request(npcs_pkg::FN_PROG_BYTE));
        r = rand_request(npcs_pkg::FN_START_READ);
        r.addr = 28'h00007FE;
        r.len  = 28'd3;
        requests_pending.push_back(r);
        requests_pending.push_back(rand_request(npcs_pkg::FN_READ_ID));
        repeat (3) requests_pending.push_back(rand_request(npcs_pkg::FN_NEXT_READ));
        // last page of the address space, spilling past it
        r = rand_request(npcs_pkg::FN_START_PROG);
        r.addr = '1;
        r.len  = 28'd2;
        requests_pending.push_back(r);
        requests_pending.push_back(rand_request(npcs_pkg::FN_ERASE));
        r = rand_request(npcs_pkg::FN_PROG_BYTE);
        r.data = 8'h00;
        requests_pending.push_back(r);
        r.data = 8'hFF;
        requests_pending.push_back(r);
        // length runs out exactly at the page end
        queue_transfer(npcs_pkg::FN_START_PROG, 28'h1234FFF, 28'd1, 1, 0);

        while (requests_pending.size() < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                requests_pending.push_back(rand_request(npcs_pkg::FN_READ_ID));
            end else if (pick < 18) begin
                requests_pending.push_back(rand_request(npcs_pkg::FN_ERASE));
            end else if (pick < 24) begin
                case ($urandom_range(0, 3))
                    0:       fn = npcs_pkg::FN_NEXT_READ;
                    1:       fn = npcs_pkg::FN_PROG_BYTE;
                    2:       fn = FN_UNUSED_A;
                    default: fn = FN_UNUSED_B;
                endcase
                requests_pending.push_back(rand_request(fn));
            end else if (pick < 28) begin
                fn = pick[0] ? npcs_pkg::FN_START_READ : npcs_pkg::FN_START_PROG;
                queue_transfer(fn, 28'($urandom()), '0, 0, 0);
            end else begin
                fn   = (pick < 64) ? npcs_pkg::FN_START_READ : npcs_pkg::FN_START_PROG;
                addr = 28'($urandom());
                // start near the page end so that short runs turn the page
                if ($urandom_range(0, 2) == 0)
                    addr[10:0] = 11'(PAGE_BYTES - $urandom_range(1, 6));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                queue_transfer(fn, addr, 28'(len), len, 12);
            end
        end
        // longest length: left open at the end of the run
        queue_transfer(npcs_pkg::FN_START_PROG, 28'($urandom()), '1, 4, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_pending.size() != 0 || push) @(negedge i_clk);
        while (bus_words_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests (%0d rejected, %0d erases, %0d page turns), %0d bus words.",
                 items_taken, reject_count, erase_count, page_turns, words_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad bus words.", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
